FILE: rtl/lzsd_pkg.sv
// shared constants and types for the lzss byte decoder
package lzsd_pkg;

    localparam int HIST_DEPTH  = 4096;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int POS_W       = 24;
    localparam int BYTE_W      = 8;
    localparam int LIMIT_W     = 24;
    localparam int BITS_W      = 4;
    localparam int LEN_W       = 5;
    localparam int DIST_W      = HIST_AW + 1;

    localparam logic [HIST_AW-1:0] OFFSET_BIAS = HIST_AW'(19);
    localparam logic [LEN_W-1:0]   MIN_LEN     = LEN_W'(3);
    localparam logic [BITS_W-1:0]  FLAG_COUNT  = BITS_W'(8);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

    // history write port beat
    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] addr;
        logic [BYTE_W-1:0]  data;
    } t_hist_wr;

endpackage

FILE: rtl/lzsd_if.sv
// valid/ready channels for compressed input, decoded output and configuration
interface lzsd_in_if import lzsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              start_req;

    modport source (output valid, output in_byte, output start_req, input ready);
    modport sink   (input valid, input in_byte, input start_req, output ready);
endinterface

interface lzsd_out_if import lzsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

interface lzsd_cfg_if import lzsd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] output_limit;

    modport source (output valid, output output_limit, input ready);
    modport sink   (input valid, input output_limit, output ready);
endinterface

FILE: rtl/lzsd_hist.sv
// 4096 x 8 history memory, one write and one registered read per cycle
module lzsd_hist import lzsd_pkg::*; (
    input  logic               i_clk,
    input  t_hist_wr           i_wr,
    input  logic [HIST_AW-1:0] i_rd_addr,
    output logic [BYTE_W-1:0]  o_rd_data
);

    logic [BYTE_W-1:0] r_mem [HIST_DEPTH];
    logic [BYTE_W-1:0] r_rd;

    // write port, read returns contents before a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

FILE: rtl/lzss_byte_decoder.sv
// lzss decoder top level: flag/literal/reference parsing and history copy engine
// a literal appears on the output in the cycle after its input beat is taken
// a reference gives 3 to 18 bytes, one per cycle while the output is not stalled,
// from the copy state entered after its second byte is taken; one input beat per cycle
// unless stalled, with input held off while the run is read from the history memory
// reset (sync, active low) clears decoder state and sets output_limit to 0xFFFFFF
module lzss_byte_decoder import lzsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzsd_in_if.sink     i_in,
    lzsd_out_if.source  o_out,
    lzsd_cfg_if.sink    i_cfg
);

    typedef enum logic {S_IDLE, S_COPY} t_state;

    t_state             r_state, n_state;
    logic [BYTE_W-1:0]  r_flags, n_flags;
    logic [BITS_W-1:0]  r_bits, n_bits;
    logic [BYTE_W-1:0]  r_pend, n_pend;
    logic               r_have, n_have;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [LIMIT_W-1:0] r_limit;
    logic [HIST_AW-1:0] r_src, n_src;
    logic [LEN_W-1:0]   r_remain, n_remain;
    logic [LEN_W-1:0]   r_zeros, n_zeros;
    logic               r_dist_one, n_dist_one;
    logic [BYTE_W-1:0]  r_last;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_last;

    logic               out_free, in_fire, start;
    logic [BYTE_W-1:0]  e_flags;
    logic [BITS_W-1:0]  e_bits;
    logic               e_have;
    logic [POS_W-1:0]   e_pos;
    logic [HIST_AW-1:0] offset, src0;
    logic [DIST_W-1:0]  ref_dist, zeros_raw;
    logic [LEN_W-1:0]   len, zeros;
    logic               before_start;
    logic               copy_emit, lit_emit, emit, emit_last;
    logic [BYTE_W-1:0]  copy_byte, emit_byte, hist_rd;
    t_hist_wr           hist_wr;

    // handshakes
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && out_free;
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign start       = in_fire && i_in.start_req;

    // state as seen by this beat, after an optional stream restart
    assign e_flags = start ? '0 : r_flags;
    assign e_bits  = start ? '0 : r_bits;
    assign e_have  = start ? 1'b0 : r_have;
    assign e_pos   = start ? '0 : r_pos;

    // reference decode: ring offset, distance, length, leading zero fill
    assign offset       = {i_in.in_byte[7:4], r_pend};
    assign ref_dist     = {1'b0, e_pos[HIST_AW-1:0] - offset - OFFSET_BIAS} + DIST_W'(1);
    assign len          = {1'b0, i_in.in_byte[3:0]} + MIN_LEN;
    assign before_start = e_pos < {{(POS_W-DIST_W){1'b0}}, ref_dist};
    assign zeros_raw    = ref_dist - e_pos[DIST_W-1:0];
    assign src0         = e_pos[HIST_AW-1:0] - ref_dist[HIST_AW-1:0];

    always_comb begin
        if (!before_start) begin
            zeros = '0;
        end else if (zeros_raw > {{(DIST_W-LEN_W){1'b0}}, len}) begin
            zeros = len;
        end else begin
            zeros = zeros_raw[LEN_W-1:0];
        end
    end

    // byte emission: literal or one byte of a copy run
    assign copy_emit = (r_state == S_COPY) && out_free;
    assign lit_emit  = in_fire && (e_bits != '0) && e_flags[0];
    assign emit      = copy_emit || lit_emit;
    assign copy_byte = (r_zeros != '0) ? '0 : (r_dist_one ? r_last : hist_rd);
    assign emit_byte = copy_emit ? copy_byte : i_in.in_byte;
    assign emit_last = copy_emit ? (r_remain == LEN_W'(1)) : 1'b1;

    // history write at the current position
    assign hist_wr.we   = emit;
    assign hist_wr.addr = e_pos[HIST_AW-1:0];
    assign hist_wr.data = emit_byte;

    lzsd_hist u_hist (
        .i_clk     (i_clk),
        .i_wr      (hist_wr),
        .i_rd_addr (n_src),
        .o_rd_data (hist_rd)
    );

    // next-state decode
    always_comb begin
        n_state    = r_state;
        n_flags    = r_flags;
        n_bits     = r_bits;
        n_pend     = r_pend;
        n_have     = r_have;
        n_src      = r_src;
        n_remain   = r_remain;
        n_zeros    = r_zeros;
        n_dist_one = r_dist_one;
        n_pos      = e_pos + POS_W'(emit);

        if (in_fire) begin
            n_flags = e_flags;
            n_bits  = e_bits;
            n_have  = e_have;
            priority if (e_bits == '0) begin
                if (e_pos < r_limit) begin
                    n_flags = i_in.in_byte;
                    n_bits  = FLAG_COUNT;
                end
            end else if (e_flags[0]) begin
                n_flags = e_flags >> 1;
                n_bits  = e_bits - BITS_W'(1);
            end else if (!e_have) begin
                n_pend = i_in.in_byte;
                n_have = 1'b1;
            end else begin
                n_flags    = e_flags >> 1;
                n_bits     = e_bits - BITS_W'(1);
                n_have     = 1'b0;
                n_state    = S_COPY;
                n_remain   = len;
                n_zeros    = zeros;
                n_dist_one = (ref_dist == DIST_W'(1));
                n_src      = src0;
            end
        end else if (copy_emit) begin
            n_src    = r_src + HIST_AW'(1);
            n_remain = r_remain - LEN_W'(1);
            if (r_zeros != '0) begin
                n_zeros = r_zeros - LEN_W'(1);
            end
            if (r_remain == LEN_W'(1)) begin
                n_state = S_IDLE;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flags     <= '0;
            r_bits      <= '0;
            r_have      <= 1'b0;
            r_pos       <= '0;
            r_limit     <= LIMIT_RESET;
            r_remain    <= '0;
            r_zeros     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_flags  <= n_flags;
            r_bits   <= n_bits;
            r_have   <= n_have;
            r_pos    <= n_pos;
            r_remain <= n_remain;
            r_zeros  <= n_zeros;
            if (i_cfg.valid) begin
                r_limit <= i_cfg.output_limit;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend     <= n_pend;
        r_src      <= n_src;
        r_dist_one <= n_dist_one;
        if (emit) begin
            r_last     <= emit_byte;
            r_out_byte <= emit_byte;
            r_out_last <= emit_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.run_last = r_out_last;

    // a copy run always has bytes left and never more zeros than bytes
    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_remain != '0) && (r_zeros <= r_remain))
        else $error("copy run count out of range");

    // every emitted beat outside a stream restart advances the position by one
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !start) |=> (r_pos == $past(r_pos) + POS_W'(1)))
        else $error("position did not advance with emitted beat");

    // the final copy beat closes the run and is marked last
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (copy_emit && (r_remain == LEN_W'(1))) |=> (r_state == S_IDLE) && o_out.run_last)
        else $error("copy run did not end cleanly");

endmodule

FILE: tb/lzsd_out_checker.sv
`timescale 1ns / 1ps
// checker for the lzss byte decoder: decodes accepted input beats and compares output beats
module lzsd_out_checker import lzsd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lzsd_in_if   i_in,
    lzsd_out_if  i_out,
    lzsd_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_last;
    } t_dec_byte;

    // decoded bytes still owed by the block, oldest first
    t_dec_byte          owed_bytes[$];

    // decoder state as the block should hold it
    logic [LIMIT_W-1:0] limit_q;
    logic [BYTE_W-1:0]  flags_q;
    logic [BITS_W-1:0]  bits_left_q;
    logic [BYTE_W-1:0]  ref_low_q;
    logic               ref_open_q;
    logic [POS_W-1:0]   pos_q;
    logic [BYTE_W-1:0]  ring [HIST_DEPTH];
    int                 fails = 0;

    // back to the start of a stream, history kept
    task automatic clear_stream();
        flags_q     = '0;
        bits_left_q = '0;
        ref_low_q   = '0;
        ref_open_q  = 1'b0;
        pos_q       = '0;
    endtask

    // one decoded byte: into the ring and onto the owed list
    task automatic emit_byte(input logic [BYTE_W-1:0] v);
        ring[pos_q[HIST_AW-1:0]] = v;
        pos_q = pos_q + 1'b1;
        owed_bytes.push_back(t_dec_byte'{data: v, run_last: 1'b0});
    endtask

    // decode one compressed byte into the bytes it completes
    task automatic decode_beat(input logic [BYTE_W-1:0] b, input logic s);
        logic [HIST_AW-1:0] off;
        logic [HIST_AW-1:0] d12;
        logic [HIST_AW-1:0] src;
        int                 span;
        int                 len;
        int                 zeros;
        t_dec_byte          tail;

        if (s) clear_stream();

        // flag byte, dropped once the limit is reached
        if (bits_left_q == '0) begin
            if (pos_q < limit_q) begin
                flags_q     = b;
                bits_left_q = FLAG_COUNT;
            end
            return;
        end

        if (flags_q[0]) begin
            emit_byte(b);
        end else if (!ref_open_q) begin
            // low offset byte, nothing out yet
            ref_low_q  = b;
            ref_open_q = 1'b1;
            return;
        end else begin
            off  = {b[7:4], ref_low_q};
            d12  = pos_q[HIST_AW-1:0] - off - OFFSET_BIAS;
            span = int'(d12) + 1;
            len  = int'(b[3:0]) + int'(MIN_LEN);
            // source before the stream start reads as zeros
            if (span > int'(pos_q)) begin
                zeros = span - int'(pos_q);
                if (zeros > len) zeros = len;
                len = len - zeros;
                repeat (zeros) emit_byte('0);
            end
            // copy from the ring, overlap allowed
            repeat (len) begin
                src = pos_q[HIST_AW-1:0] - HIST_AW'(span);
                emit_byte(ring[src]);
            end
            ref_open_q = 1'b0;
        end

        flags_q     = flags_q >> 1;
        bits_left_q = bits_left_q - 1'b1;

        // last byte of this beat carries run_last
        tail = owed_bytes.pop_back();
        tail.run_last = 1'b1;
        owed_bytes.push_back(tail);
    endtask

    // predict on input beats, then compare output beats
    always @(posedge i_clk) begin
        t_dec_byte want;
        if (!i_rst_n) begin
            limit_q = LIMIT_RESET;
            clear_stream();
            owed_bytes.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) limit_q = i_cfg.output_limit;
            if (i_in.valid && i_in.ready) decode_beat(i_in.in_byte, i_in.start_req);
            if (i_out.valid && i_out.ready) begin
                if (owed_bytes.size() == 0) begin
                    $error("unexpected output beat: out_byte %02h run_last %0b",
                           i_out.out_byte, i_out.run_last);
                    fails++;
                end else begin
                    want = owed_bytes.pop_front();
                    if (i_out.out_byte !== want.data) begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.data, i_out.out_byte);
                        fails++;
                    end
                    if (i_out.run_last !== want.run_last) begin
                        $error("run_last mismatch: expected %0b, actual %0b",
                               want.run_last, i_out.run_last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= owed_bytes.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the lzss byte decoder: clock, reset, stream generation and verdict
module tb_top;
    import lzsd_pkg::*;

    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int LONG_GOAL     = 900;

    logic               i_clk;
    logic               i_rst_n;
    int                 fail_cnt;
    int                 pend_cnt;
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    int                 item_cnt    = 0;
    int                 gen_pos     = 0;
    int                 hold_left   = 0;
    int                 quiet_cycles = 0;
    logic               hold_arm  = 1'b0;
    logic               hold_done = 1'b0;
    logic [LIMIT_W-1:0] cur_limit = LIMIT_RESET;

    lzsd_in_if  in_ch ();
    lzsd_out_if out_ch ();
    lzsd_cfg_if cfg_ch ();

    lzss_byte_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    lzsd_out_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_cnt),
        .o_pending    (pend_cnt)
    );

    // 50 MHz clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // output side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input beat with random idle cycles ahead of it
    task automatic put_beat(input logic [BYTE_W-1:0] b, input logic s, input bit counted);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= b;
        in_ch.start_req <= s;
        do @(posedge i_clk); while (!in_ch.ready);
        if (counted) item_cnt++;
    endtask

    // wait until every owed byte is out and the block has gone quiet
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pend_cnt != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] v);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.output_limit <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_limit = v;
    endtask

    task automatic send_flag(input logic [BYTE_W-1:0] f, input logic s);
        if (s) gen_pos = 0;
        put_beat(f, s, 1'b1);
    endtask

    task automatic send_lit(input logic [BYTE_W-1:0] b);
        put_beat(b, 1'b0, 1'b1);
        gen_pos++;
    endtask

    task automatic send_ref_raw(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
        put_beat(lo, 1'b0, 1'b1);
        put_beat(hi, 1'b0, 1'b1);
        gen_pos += int'(hi[3:0]) + int'(MIN_LEN);
    endtask

    // reference aimed at a given distance back from the current output position
    task automatic send_ref(input int back, input logic [3:0] nib);
        logic [HIST_AW-1:0] off;
        off = HIST_AW'(gen_pos) - OFFSET_BIAS - HIST_AW'(back - 1);
        send_ref_raw(off[7:0], {off[11:8], nib});
    endtask

    // random reference: short overlapping copies, far copies, full window, raw offsets
    task automatic send_any_ref(input bit long_run);
        int         kind;
        int         reach;
        logic [3:0] nib;
        nib   = long_run ? 4'($urandom_range(15, 12)) : 4'($urandom_range(15));
        kind  = $urandom_range(99);
        reach = (gen_pos < HIST_DEPTH) ? gen_pos : HIST_DEPTH;
        if (reach == 0 || kind < 12) begin
            send_ref_raw(8'($urandom), {4'($urandom), nib});
        end else if (kind < 45) begin
            send_ref($urandom_range((reach < 8) ? reach : 8, 1), nib);
        end else if (kind < 55) begin
            send_ref(reach, nib);
        end else begin
            send_ref($urandom_range(reach, 1), nib);
        end
    endtask

    // one image: flag groups until both the group count and the position goal are met or it is cut off
    task automatic send_image(input int groups, input bit long_run, input int pos_goal);
        logic [BYTE_W-1:0] flags;
        bit                opening;
        int                g;
        opening = 1'b1;
        g = 0;
        while (g < groups || gen_pos < pos_goal) begin
            // limit reached: the block drops everything up to the next image
            if (!opening && gen_pos >= cur_limit) begin
                repeat ($urandom_range(3, 1)) put_beat(8'($urandom), 1'b0, 1'b0);
                return;
            end
            flags = long_run ? 8'($urandom & $urandom & $urandom) : 8'($urandom);
            send_flag(flags, opening);
            opening = 1'b0;
            for (int k = 0; k < 8; k++) begin
                // broken group, cut off by the next image
                if (!long_run && $urandom_range(99) < 2) return;
                if (flags[k]) send_lit(8'($urandom));
                else send_any_ref(long_run);
            end
            g++;
        end
    endtask

    task automatic run_images(input int n);
        item_cnt = 0;
        while (item_cnt < n) send_image($urandom_range(6, 1), 1'b0, 0);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = '0;
        in_ch.start_req     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.output_limit = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: literals at both byte extremes, zero fill, overlap, partial zero fill
        set_limit(LIMIT_RESET);
        send_flag(8'h05, 1'b1);
        send_lit(8'h00);
        send_ref_raw(8'hFF, 8'hFF);
        send_lit(8'hFF);
        send_ref(1, 4'h0);
        send_ref(gen_pos, 4'hF);
        send_ref_raw(8'h00, 8'h00);
        send_ref(gen_pos + 2, 4'h2);
        send_ref(3, 4'hF);
        // new image mid-group and with a reference half taken
        send_flag(8'hFF, 1'b1);
        send_lit(8'h80);
        send_flag(8'h00, 1'b1);
        put_beat(8'h12, 1'b0, 1'b1);
        send_flag(8'h01, 1'b1);
        send_lit(8'hAA);
        drain();

        // limit of one: the open group completes, the next flag byte is dropped
        set_limit(LIMIT_W'(1));
        send_flag(8'hFF, 1'b1);
        repeat (8) send_lit(8'($urandom));
        put_beat(8'hFF, 1'b0, 1'b0);
        drain();

        // limit of zero: every flag byte is dropped
        set_limit('0);
        put_beat(8'h5A, 1'b1, 1'b0);
        put_beat(8'h01, 1'b0, 1'b0);
        drain();

        // slow receiver, with one long hold-off while the sender keeps going
        tx_idle_pct = 6;
        rx_idle_pct = 45;
        set_limit(LIMIT_W'($urandom_range(700, 60)));
        run_images(25);
        hold_arm <= 1'b1;
        run_images(45);
        drain();

        // slow sender, tight limits
        tx_idle_pct = 45;
        rx_idle_pct = 6;
        set_limit(LIMIT_W'($urandom_range(150, 1)));
        run_images(75);
        drain();

        // full speed: one long image made mostly of long copy runs, then more random images
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_limit(LIMIT_RESET);
        send_image(1, 1'b1, LONG_GOAL);
        run_images(35);
        drain();

        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: lzss_byte_decoder.f
rtl/lzsd_pkg.sv
rtl/lzsd_if.sv
rtl/lzsd_hist.sv
rtl/lzss_byte_decoder.sv
tb/lzsd_out_checker.sv
tb/tb_top.sv
